@@ sv/dnd_pkg.sv @@
// ----------------------------------------------------------------------------
// dnd_pkg
// Widths, term indexes and small helpers shared by the Delta-Notch rate
// datapath and the testbench that checks it.
// ----------------------------------------------------------------------------
package dnd_pkg;

	localparam int IN_W    = 32;
	localparam int OUT_W   = 48;
	localparam int N_IN    = 8;
	localparam int N_OUT   = 6;
	localparam int DIV_NW  = 76;   // widest dividend: 2514 * 32b * 32b
	localparam int DIV_DW  = 35;   // widest divisor: 3 * (10 + I)
	localparam int TERM_W  = 61;   // flux terms clamp at 2^60
	localparam int SUM_W   = 66;
	localparam int N_DIV   = 5;

	// divider lanes
	localparam int DV_R1  = 0;
	localparam int DV_R5  = 1;
	localparam int DV_R10 = 2;
	localparam int DV_R8B = 3;
	localparam int DV_BD  = 4;

	localparam logic [TERM_W-1:0] TERM_CAP = {1'b1, {(TERM_W-1){1'b0}}};

	// flux terms that need no divider lane
	typedef struct packed {
		logic [TERM_W-1:0] r2;
		logic [TERM_W-1:0] r3;
		logic [TERM_W-1:0] r4;
		logic [TERM_W-1:0] r6;
		logic [TERM_W-1:0] r7;
		logic [TERM_W-1:0] r8a;
		logic [TERM_W-1:0] r9;
		logic [TERM_W-1:0] r11;
		logic [TERM_W-1:0] r12;
		logic [TERM_W-1:0] r13;
		logic [TERM_W-1:0] rc;
		logic [TERM_W-1:0] decay;
	} side_t;

	// clamp a quotient or product to the term cap
	function automatic logic [TERM_W-1:0] clamp_term(input logic [DIV_NW-1:0] v);
		logic [DIV_NW-1:0] cap;
		cap = DIV_NW'(TERM_CAP);
		return (v > cap) ? TERM_CAP : v[TERM_W-1:0];
	endfunction

	// zero-extend a term into the signed sum width
	function automatic logic signed [SUM_W-1:0] ext(input logic [TERM_W-1:0] t);
		return $signed({{(SUM_W-TERM_W){1'b0}}, t});
	endfunction

	// saturate a sum to the output range
	function automatic logic [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = $signed({{(SUM_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}});
		lo = -hi - SUM_W'(1);
		if (v > hi) begin
			return {1'b0, {(OUT_W-1){1'b1}}};
		end else if (v < lo) begin
			return {1'b1, {(OUT_W-1){1'b0}}};
		end
		return v[OUT_W-1:0];
	endfunction

endpackage

@@ sv/dnd_div.sv @@
// ----------------------------------------------------------------------------
// dnd_div
// Pipelined restoring divider: one quotient bit per stage, NW stages.
// ----------------------------------------------------------------------------
module dnd_div #(
	parameter int NW = 76,
	parameter int DW = 35
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [NW-1:0] quot
);

	logic [NW-1:0] num_s [NW+1];
	logic [DW-1:0] rem_s [NW+1];
	logic [DW-1:0] den_s [NW+1];

	assign num_s[0] = num;
	assign rem_s[0] = '0;
	assign den_s[0] = den;

	// shift one dividend bit into the remainder, subtract when it fits
	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [DW:0] trial;
		logic        fits;
		logic [DW:0] diff;

		assign trial = {rem_s[k], num_s[k][NW-1]};
		assign fits  = trial >= {1'b0, den_s[k]};
		assign diff  = fits ? (trial - {1'b0, den_s[k]}) : trial;

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[k+1] <= {num_s[k][NW-2:0], fits};
				rem_s[k+1] <= diff[DW-1:0];
				den_s[k+1] <= den_s[k];
			end
		end
	end

	assign quot = num_s[NW];

endmodule

@@ sv/delta_notch_ode_derivatives.sv @@
// ----------------------------------------------------------------------------
// delta_notch_ode_derivatives
// Six time derivatives of the Delta-Notch reaction system for one cell,
// fixed point, with five Hill-type ratios on pipelined dividers.
// ----------------------------------------------------------------------------
// channel | dir | payload                                   | handshake
// s_      | in  | 8 x 32b unsigned concentrations           | tvalid/tready
// m_      | out | 6 x 48b signed saturated derivatives      | tvalid/tready
//
// One request enters per cycle while the output is not stalled; each result
// passes two operand stages, one divider stage per quotient bit, a sum
// stage and the output register.
// Reset clears only the valid bits; the data registers are not reset.
// A stalled output freezes the whole pipeline, s_tready drops with it.
// ----------------------------------------------------------------------------
module delta_notch_ode_derivatives #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// surface_notch, sudx_notch, early_endosome_notch, late_endosome_notch,
	// intracellular_domain, delta_level, neighbour_mean_delta, distance_factor
	input  logic [255:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// d_surface_notch, d_sudx_notch, d_early_endosome, d_late_endosome,
	// d_intracellular, d_delta_level
	output logic [287:0] m_tdata
);

	localparam int NW = dnd_pkg::DIV_NW;
	localparam int DW = dnd_pkg::DIV_DW;
	localparam int IW = dnd_pkg::IN_W;
	localparam int OW = dnd_pkg::OUT_W;
	localparam int TW = dnd_pkg::TERM_W;

	localparam logic [NW-1:0] TEN_ONE  = NW'(10) << FRAC_BITS;
	localparam logic [NW-1:0] FOURTEEN = NW'(14) << FRAC_BITS;
	localparam logic [NW-1:0] NUM1     = NW'(140) << (2 * FRAC_BITS);
	localparam logic [NW-1:0] R1_BASE  = NW'(28) << FRAC_BITS;
	// reciprocals for the constant divisions: ceil(2^34 / 5), ceil(2^38 / 25)
	localparam logic [NW-1:0] RECIP5   = NW'(64'd3435973837);
	localparam logic [NW-1:0] RECIP25  = NW'(64'd10995116278);

	logic en;

	// whole pipeline advances unless the output holds an untaken result
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// stage 1: register fields and form the four wide products
	logic          v_s1;
	logic [IW-1:0] fld_s1 [dnd_pkg::N_IN];
	logic [63:0]   pdn3_s1, pdn2_s1, pmn1_s1, pnd_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < dnd_pkg::N_IN; i++) begin
				fld_s1[i] <= s_tdata[i*IW +: IW];
			end
			pdn3_s1 <= 64'(s_tdata[5*IW +: IW]) * 64'(s_tdata[2*IW +: IW]);
			pdn2_s1 <= 64'(s_tdata[5*IW +: IW]) * 64'(s_tdata[1*IW +: IW]);
			pmn1_s1 <= 64'(s_tdata[6*IW +: IW]) * 64'(s_tdata[0*IW +: IW]);
			pnd_s1  <= 64'(s_tdata[0*IW +: IW]) * 64'(s_tdata[5*IW +: IW]);
		end
	end

	// stage 2: dividends, divisors and the terms that need no divider
	logic                 v_s2;
	logic [NW-1:0]        dnum_s2 [dnd_pkg::N_DIV];
	logic [DW-1:0]        dden_s2 [dnd_pkg::N_DIV];
	dnd_pkg::side_t       side_s2;
	logic [NW-1:0]        den_i, den_d, den_8;
	logic [NW-1:0]        n1w, n2w, n3w, n4w, niw, dlw, xdw;

	always_comb begin
		n1w   = NW'(fld_s1[0]);
		n2w   = NW'(fld_s1[1]);
		n3w   = NW'(fld_s1[2]);
		n4w   = NW'(fld_s1[3]);
		niw   = NW'(fld_s1[4]);
		dlw   = NW'(fld_s1[5]);
		xdw   = NW'(fld_s1[7]);
		den_i = TEN_ONE + niw;
		den_d = TEN_ONE + dlw;
		den_8 = FOURTEEN + n3w;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dnum_s2[dnd_pkg::DV_R1]  <= NUM1 + den_i - NW'(1);
			dden_s2[dnd_pkg::DV_R1]  <= den_i[DW-1:0];
			dnum_s2[dnd_pkg::DV_R5]  <= NW'(pdn3_s1) * NW'(1000);
			dden_s2[dnd_pkg::DV_R5]  <= den_d[DW-1:0];
			dnum_s2[dnd_pkg::DV_R10] <= NW'(pdn2_s1) * NW'(2514);
			dden_s2[dnd_pkg::DV_R10] <= den_d[DW-1:0];
			dnum_s2[dnd_pkg::DV_R8B] <= (n3w * NW'(14)) << FRAC_BITS;
			dden_s2[dnd_pkg::DV_R8B] <= den_8[DW-1:0];
			dnum_s2[dnd_pkg::DV_BD]  <= (xdw * NW'(175)) << FRAC_BITS;
			dden_s2[dnd_pkg::DV_BD]  <= DW'(den_i * NW'(3));
			side_s2.r2    <= TW'(n1w * NW'(10));
			side_s2.r3    <= TW'(n1w * NW'(2414));
			side_s2.r4    <= TW'(n1w * NW'(4214));
			side_s2.r6    <= dnd_pkg::clamp_term((NW'(pmn1_s1) * NW'(500)) >> FRAC_BITS);
			side_s2.r7    <= TW'(n2w * NW'(15));
			// 6/5 of N3 is N3 plus N3/5
			side_s2.r8a   <= TW'(n3w + ((n3w * RECIP5) >> 34));
			side_s2.r9    <= TW'(n4w * NW'(1094));
			side_s2.r11   <= TW'(n3w);
			side_s2.r12   <= TW'(n4w * NW'(70));
			// 3I/50 as (3I/2)/25
			side_s2.r13   <= TW'((((niw * NW'(3)) >> 1) * RECIP25) >> 38);
			side_s2.rc    <= dnd_pkg::clamp_term((NW'(pnd_s1) * NW'(1000)) >> FRAC_BITS);
			side_s2.decay <= TW'(dlw >> 2);
		end
	end

	// divider lanes
	logic [NW-1:0] quot [dnd_pkg::N_DIV];

	for (genvar d = 0; d < dnd_pkg::N_DIV; d++) begin : g_div
		dnd_div #(
			.NW(NW),
			.DW(DW)
		) u_div (
			.clk (clk),
			.en  (en),
			.num (dnum_s2[d]),
			.den (dden_s2[d]),
			.quot(quot[d])
		);
	end

	// carry the direct terms and valid bits alongside the dividers
	logic           v_line_q [NW];
	dnd_pkg::side_t side_line_q [NW];

	always_ff @(posedge clk) begin
		if (en) begin
			side_line_q[0] <= side_s2;
			for (int k = 1; k < NW; k++) begin
				side_line_q[k] <= side_line_q[k-1];
			end
		end
	end

	// stage 3: sum each derivative exactly
	logic                          v_s3;
	logic signed [dnd_pkg::SUM_W-1:0] sum_s3 [dnd_pkg::N_OUT];
	logic signed [dnd_pkg::SUM_W-1:0] r1, r5, r8, r10, r13, bd;
	dnd_pkg::side_t                   sd;

	always_comb begin
		sd  = side_line_q[NW-1];
		r1  = dnd_pkg::ext(TW'(R1_BASE)) - dnd_pkg::ext(dnd_pkg::clamp_term(quot[dnd_pkg::DV_R1]));
		r5  = dnd_pkg::ext(dnd_pkg::clamp_term(quot[dnd_pkg::DV_R5]));
		r10 = dnd_pkg::ext(dnd_pkg::clamp_term(quot[dnd_pkg::DV_R10]));
		r8  = dnd_pkg::ext(sd.r8a)
		    + dnd_pkg::ext(dnd_pkg::clamp_term(quot[dnd_pkg::DV_R8B]));
		r13 = dnd_pkg::ext(sd.r13);
		bd  = dnd_pkg::ext(dnd_pkg::clamp_term(quot[dnd_pkg::DV_BD]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3[0] <= r1 - dnd_pkg::ext(sd.r2) - dnd_pkg::ext(sd.r3)
			           - dnd_pkg::ext(sd.r4) - dnd_pkg::ext(sd.r6);
			sum_s3[1] <= dnd_pkg::ext(sd.r3) + r5 + dnd_pkg::ext(sd.r7) - r10;
			sum_s3[2] <= dnd_pkg::ext(sd.r4) - r5 - r8 - dnd_pkg::ext(sd.r11);
			sum_s3[3] <= r8 - dnd_pkg::ext(sd.r9) - dnd_pkg::ext(sd.r12);
			sum_s3[4] <= dnd_pkg::ext(sd.r6) + dnd_pkg::ext(sd.r7)
			           + dnd_pkg::ext(sd.r9) - r13;
			sum_s3[5] <= bd - dnd_pkg::ext(sd.decay) - dnd_pkg::ext(sd.r6)
			           - dnd_pkg::ext(sd.rc);
		end
	end

	// stage 4: saturate into the output register
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < dnd_pkg::N_OUT; i++) begin
				m_tdata[i*OW +: OW] <= dnd_pkg::sat_out(sum_s3[i]);
			end
		end
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			m_tvalid <= 1'b0;
			for (int k = 0; k < NW; k++) begin
				v_line_q[k] <= 1'b0;
			end
		end else if (en) begin
			v_s1        <= s_tvalid;
			v_s2        <= v_s1;
			v_line_q[0] <= v_s2;
			for (int k = 1; k < NW; k++) begin
				v_line_q[k] <= v_line_q[k-1];
			end
			v_s3     <= v_line_q[NW-1];
			m_tvalid <= v_s3;
		end
	end

endmodule

@@ sv/dnd_chk.sv @@
// ----------------------------------------------------------------------------
// dnd_chk
// Port-level checks of the rate datapath's flow control.
// ----------------------------------------------------------------------------
module dnd_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [287:0] m_tdata
);

	// a held result keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// a stalled output blocks new requests
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("request taken during output stall");

	// an empty or draining output never blocks the input
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid || m_tready |-> s_tready)
		else $error("input blocked without output stall");

	// while stalled, the input stays closed on the next cycle too
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready ##1 !m_tready |-> !s_tready)
		else $error("input opened while output still stalled");

endmodule

bind delta_notch_ode_derivatives dnd_chk u_dnd_chk (.*);

@@ tb/dnd_rate_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dnd_rate_checker
// Watches both stream channels of the Delta-Notch rate block. Every
// accepted request is turned into six expected derivatives, and every
// accepted result is compared field by field with the oldest of them.
// ----------------------------------------------------------------------------
module dnd_rate_checker #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	input  logic                                  s_tready,
	input  logic [dnd_pkg::N_IN*dnd_pkg::IN_W-1:0]   s_tdata,
	input  logic                                  m_tvalid,
	input  logic                                  m_tready,
	input  logic [dnd_pkg::N_OUT*dnd_pkg::OUT_W-1:0] m_tdata,
	output int                                    mismatches,
	output int                                    outstanding
);

	localparam int IW = dnd_pkg::IN_W;
	localparam int OW = dnd_pkg::OUT_W;
	localparam logic [127:0] ONE  = 128'd1 << FRAC_BITS;
	localparam logic [127:0] FLUX_MAX = 128'd1 << 60;

	typedef logic [dnd_pkg::N_OUT*OW-1:0] rates_t;

	rates_t expected_rates[$];

	// floor(k * a * b / den), limited to the flux cap
	function automatic logic signed [127:0] flux(input logic [127:0] k, input logic [127:0] a,
			input logic [127:0] b, input logic [127:0] den);
		logic [127:0] v;
		v = (k * a * b) / den;
		if (v > FLUX_MAX) begin
			v = FLUX_MAX;
		end
		return $signed(v);
	endfunction

	// clamp an exact sum to the 48-bit signed range
	function automatic logic [OW-1:0] clamp48(input logic signed [127:0] v);
		logic signed [127:0] hi;
		hi = (128'sd1 <<< (OW - 1)) - 1;
		if (v > hi) begin
			return {1'b0, {(OW-1){1'b1}}};
		end else if (v < -hi - 1) begin
			return {1'b1, {(OW-1){1'b0}}};
		end
		return v[OW-1:0];
	endfunction

	// six derivatives of one cell
	function automatic rates_t cell_rates(input logic [dnd_pkg::N_IN*IW-1:0] conc);
		logic [127:0] n1, n2, n3, n4, ni, dl, md, xd, den_i, den_d;
		logic signed [127:0] r1, r2, r3, r4, r5, r6, r7, r8, r9, r10, r11, r12, r13, rc, bd, decay;
		rates_t res;
		n1 = conc[0*IW +: IW];
		n2 = conc[1*IW +: IW];
		n3 = conc[2*IW +: IW];
		n4 = conc[3*IW +: IW];
		ni = conc[4*IW +: IW];
		dl = conc[5*IW +: IW];
		md = conc[6*IW +: IW];
		xd = conc[7*IW +: IW];
		den_i = 10 * ONE + ni;
		den_d = 10 * ONE + dl;
		// production term rounds its ratio up, so the flux rounds down
		r1 = $signed(28 * ONE) - $signed((140 * ONE * ONE + den_i - 1) / den_i);
		r2 = $signed(10 * n1);
		r3 = $signed(2414 * n1);
		r4 = $signed(4214 * n1);
		r5 = flux(1000, dl, n3, den_d);
		r6 = flux(500, md, n1, ONE);
		r7 = $signed(15 * n2);
		r8 = flux(6, n3, 1, 5) + flux(14, ONE, n3, 14 * ONE + n3);
		r9 = $signed(1094 * n4);
		r10 = flux(2514, dl, n2, den_d);
		r11 = $signed(n3);
		r12 = $signed(70 * n4);
		r13 = flux(3, ni, 1, 50);
		rc = flux(1000, n1, dl, ONE);
		bd = flux(175, xd, ONE, 3 * den_i);
		decay = $signed(dl >> 2);
		res[0*OW +: OW] = clamp48(r1 - r2 - r3 - r4 - r6);
		res[1*OW +: OW] = clamp48(r3 + r5 + r7 - r10);
		res[2*OW +: OW] = clamp48(r4 - r5 - r8 - r11);
		res[3*OW +: OW] = clamp48(r8 - r9 - r12);
		res[4*OW +: OW] = clamp48(r6 + r7 + r9 - r13);
		res[5*OW +: OW] = clamp48(bd - decay - r6 - rc);
		return res;
	endfunction

	initial begin
		mismatches = 0;
		outstanding = 0;
	end

	// predict on each request, compare on each result
	always @(posedge clk) begin
		rates_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_rates = {expected_rates, cell_rates(s_tdata)};
			end
			if (m_tvalid && m_tready) begin
				if (expected_rates.size() == 0) begin
					$display("%0t: unexpected result %h", $time, m_tdata);
					mismatches = mismatches + 1;
				end else begin
					want = expected_rates.pop_front();
					for (int f = 0; f < dnd_pkg::N_OUT; f++) begin
						if (m_tdata[f*OW +: OW] !== want[f*OW +: OW]) begin
							$display("%0t: field %0d expected %h actual %h", $time, f,
								want[f*OW +: OW], m_tdata[f*OW +: OW]);
							mismatches = mismatches + 1;
						end
					end
				end
			end
			outstanding = expected_rates.size();
		end
	end

endmodule

@@ tb/delta_notch_ode_derivatives_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// delta_notch_ode_derivatives_test
// Drives cell concentrations into the Delta-Notch rate block with random
// gaps and output stalls; the checker beside the block predicts and
// compares the derivatives, and this module gives the verdict.
// ----------------------------------------------------------------------------
module delta_notch_ode_derivatives_test;

	localparam int FRAC_BITS = 16;
	localparam int IW = dnd_pkg::IN_W;
	localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [255:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [287:0] m_tdata;
	logic calm = 1'b0;
	int mismatches;
	int outstanding;

	delta_notch_ode_derivatives #(.FRAC_BITS(FRAC_BITS)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	dnd_rate_checker #(.FRAC_BITS(FRAC_BITS)) checker_i (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("** delta_notch_ode_derivatives: FAILED **");
		$finish;
	end

	// stall the result side now and then
	always @(posedge clk) begin
		m_tready <= calm || ($urandom_range(0, 99) >= 15);
	end

	// send one request, then maybe leave the input idle at random
	task automatic send_cell(input logic [255:0] conc);
		s_tdata <= conc;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		while (!calm && $urandom_range(0, 99) < 15) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// one concentration: mostly realistic, sometimes extreme or anything
	function automatic logic [31:0] pick_level(input int mode);
		case ($urandom_range(0, 9))
			0: return (mode == 2) ? 32'hFFFF_FFFF : '0;
			1: return ONE;
			default: begin
				if (mode == 0) begin
					return $urandom_range(0, 40 * ONE);
				end
				return $urandom;
			end
		endcase
	endfunction

	initial begin
		logic [255:0] conc;
		int mode;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: all zero, all max, each field max alone and at one, then all one and all lsb
		send_cell('0);
		send_cell({256{1'b1}});
		for (int f = 0; f < dnd_pkg::N_IN; f++) begin
			conc = '0;
			conc[f*IW +: IW] = 32'hFFFF_FFFF;
			send_cell(conc);
			conc = {8{ONE}};
			conc[f*IW +: IW] = 32'hFFFF_FFFF;
			send_cell(conc);
		end
		send_cell({8{ONE}});
		send_cell({8{32'h0000_0001}});

		// random cells, with a calm stretch and a full drain in between
		for (int n = 0; n < 1000; n++) begin
			if (n == 300) begin
				calm <= 1'b1;
			end
			if (n == 500) begin
				calm <= 1'b0;
			end
			if (n == 700) begin
				s_tvalid <= 1'b0;
				while (outstanding != 0) @(posedge clk);
			end
			mode = $urandom_range(0, 99) < 60 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
			for (int f = 0; f < dnd_pkg::N_IN; f++) begin
				conc[f*IW +: IW] = pick_level(mode);
			end
			send_cell(conc);
		end
		s_tvalid <= 1'b0;

		// drain, then let the pipeline settle
		while (outstanding != 0) @(posedge clk);
		repeat (dnd_pkg::DIV_NW + 20) @(posedge clk);
		if (mismatches == 0) begin
			$display("** delta_notch_ode_derivatives: PASSED **");
		end else begin
			$display("** delta_notch_ode_derivatives: FAILED **");
		end
		$finish;
	end

endmodule
